// ===== rtl/mceu_pkg.sv =====
// ============================================================================
// Matrix clock event update: shared package
// Sizes, codes and the structures passed between the sequencer, the matrix
// memory and the top level.
// ============================================================================
`default_nettype none

package mceu_pkg;

  // Group size and counter width.
  localparam int unsigned MaxProcs   = 8;
  localparam int unsigned CounterW   = 32;
  localparam int unsigned IdxW       = $clog2(MaxProcs);
  localparam int unsigned AddrW      = 2 * IdxW;
  localparam int unsigned Depth      = MaxProcs * MaxProcs;
  localparam int unsigned CountW     = $clog2(MaxProcs + 1);

  // Fixed field widths of the stream and configuration ports.
  localparam int unsigned RankW      = 3;
  localparam int unsigned ProcCountW = 4;
  localparam int unsigned ValueW     = 32;
  localparam int unsigned CfgDataW   = 4;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned InDataW    = 48;
  localparam int unsigned OutDataW   = 48;

  // Input item kinds.
  typedef enum logic [1:0] {
    OpInternal  = 2'd0,
    OpSend      = 2'd1,
    OpRecvStart = 2'd2,
    OpRecvElem  = 2'd3
  } op_e;

  // Dump reasons reported with each result beat.
  typedef enum logic [1:0] {
    RsnInternal = 2'd0,
    RsnSend     = 2'd1,
    RsnRecv     = 2'd2,
    RsnUnused   = 2'd3
  } reason_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgOwnRank   = 1'b0,
    CfgProcCount = 1'b1
  } cfg_idx_e;

  // One accepted input beat.
  typedef struct packed {
    op_e               op;
    logic [RankW-1:0]  peer;
    logic [RankW-1:0]  row;
    logic [RankW-1:0]  col;
    logic [ValueW-1:0] value;
    logic              last;
  } item_t;

  // One result beat of a dump.
  typedef struct packed {
    reason_e           reason;
    logic [RankW-1:0]  send_to;
    logic [RankW-1:0]  row;
    logic [RankW-1:0]  col;
    logic [ValueW-1:0] value;
    logic              last;
  } beat_t;

  // Effective configuration seen by the sequencer.
  typedef struct packed {
    logic [RankW-1:0]  rank;
    logic [CountW-1:0] count;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/mceu_ram.sv =====
// ============================================================================
// Matrix clock event update: counter memory
// Single write port, single read port, read data registered in the cycle after
// the read enable.
// ============================================================================
`default_nettype none

module mceu_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mceu_ctrl.sv =====
// ============================================================================
// Matrix clock event update: sequencer
// Runs the read-modify-write steps of each event against the counter memory
// and walks the matrix for a dump. Per-entry valid bits stand in for the
// cleared memory after reset.
// ============================================================================
`default_nettype none

module mceu_ctrl
  import mceu_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cfg_t                cfg_i,
  input  wire logic                item_valid_i,
  output logic                     item_ready_o,
  input  wire item_t               item_i,
  output logic                     ram_we_o,
  output logic [AddrW-1:0]         ram_waddr_o,
  output logic [CounterW-1:0]      ram_wdata_o,
  output logic                     ram_re_o,
  output logic [AddrW-1:0]         ram_raddr_o,
  input  wire logic [CounterW-1:0] ram_rdata_i,
  output logic                     beat_valid_o,
  input  wire logic                beat_ready_i,
  output beat_t                    beat_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_NEXT,
    S_RMW,
    S_DUMP_RD,
    S_DUMP_LD
  } state_e;

  state_e                state_q, state_d;
  logic [Depth-1:0]      vld_q, vld_d;
  logic                  rd_vld_q, rd_vld_d;
  logic [RankW-1:0]      src_q, src_d;
  logic                  inc_q, inc_d;
  logic                  mrg_own_q, mrg_own_d;
  logic                  mrg_row_q, mrg_row_d;
  logic                  dump_q, dump_d;
  logic                  is_inc_q, is_inc_d;
  logic [AddrW-1:0]      addr_q, addr_d;
  logic [RankW-1:0]      row_q, row_d;
  logic [RankW-1:0]      col_q, col_d;
  logic [CounterW-1:0]   val_q, val_d;
  reason_e               reason_q, reason_d;
  logic [RankW-1:0]      to_q, to_d;
  logic [IdxW-1:0]       dr_q, dr_d;
  logic [IdxW-1:0]       dc_q, dc_d;

  logic                  accept;
  logic                  rank_ok;
  logic                  elem_in;
  logic [CountW-1:0]     cnt_m1;
  logic [CounterW-1:0]   cur;
  logic [CounterW:0]     sum;
  logic [CounterW-1:0]   new_val;
  logic                  dump_end;

  assign accept       = item_valid_i && item_ready_o;
  assign item_ready_o = (state_q == S_IDLE);
  assign rank_ok      = {1'b0, cfg_i.rank} < cfg_i.count;
  assign elem_in      = ({1'b0, item_i.row} < cfg_i.count) &&
                        ({1'b0, item_i.col} < cfg_i.count);
  assign cnt_m1       = cfg_i.count - CountW'(1);
  assign dump_end     = ({1'b0, dr_q} == cnt_m1) && ({1'b0, dc_q} == cnt_m1);

  // Entries never written read as zero.
  assign cur = rd_vld_q ? ram_rdata_i : '0;

  // Saturating diagonal step, or the maximum with the received element.
  always_comb begin
    sum = {1'b0, cur} + (CounterW + 1)'(cfg_i.rank) + (CounterW + 1)'(1);
    if (is_inc_q) begin
      new_val = sum[CounterW] ? '1 : sum[CounterW-1:0];
    end else begin
      new_val = (val_q > cur) ? val_q : cur;
    end
  end

  // Dump beat built straight from the read data.
  always_comb begin
    beat_o.reason  = reason_q;
    beat_o.send_to = to_q;
    beat_o.row     = RankW'(dr_q);
    beat_o.col     = RankW'(dc_q);
    beat_o.value   = ValueW'(cur);
    beat_o.last    = dump_end;
  end
  assign beat_valid_o = (state_q == S_DUMP_LD);

  // Next-state logic and memory commands.
  always_comb begin
    state_d   = state_q;
    vld_d     = vld_q;
    rd_vld_d  = rd_vld_q;
    src_d     = src_q;
    inc_d     = inc_q;
    mrg_own_d = mrg_own_q;
    mrg_row_d = mrg_row_q;
    dump_d    = dump_q;
    is_inc_d  = is_inc_q;
    addr_d    = addr_q;
    row_d     = row_q;
    col_d     = col_q;
    val_d     = val_q;
    reason_d  = reason_q;
    to_d      = to_q;
    dr_d      = dr_q;
    dc_d      = dc_q;

    ram_we_o    = 1'b0;
    ram_waddr_o = addr_q;
    ram_wdata_o = new_val;
    ram_re_o    = 1'b0;
    ram_raddr_o = addr_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          row_d     = item_i.row;
          col_d     = item_i.col;
          val_d     = CounterW'(item_i.value);
          inc_d     = (item_i.op != OpRecvElem) && rank_ok;
          mrg_own_d = (item_i.op == OpRecvElem) && elem_in && (item_i.row == src_q) &&
                      (item_i.col != cfg_i.rank) && rank_ok;
          mrg_row_d = (item_i.op == OpRecvElem) && elem_in && (item_i.row != cfg_i.rank);
          dump_d    = (item_i.op == OpInternal) || (item_i.op == OpSend) ||
                      ((item_i.op == OpRecvElem) && item_i.last);
          to_d      = (item_i.op == OpSend) ? item_i.peer : '0;
          case (item_i.op)
            OpInternal: reason_d = RsnInternal;
            OpSend:     reason_d = RsnSend;
            default:    reason_d = RsnRecv;
          endcase
          if (item_i.op == OpRecvStart) begin
            src_d = item_i.peer;
          end
          state_d = S_NEXT;
        end
      end

      // Issue the next pending read, or start the dump.
      S_NEXT: begin
        if (inc_q || mrg_own_q || mrg_row_q) begin
          ram_re_o = 1'b1;
          if (inc_q) begin
            ram_raddr_o = {IdxW'(cfg_i.rank), IdxW'(cfg_i.rank)};
            inc_d       = 1'b0;
            is_inc_d    = 1'b1;
          end else if (mrg_own_q) begin
            ram_raddr_o = {IdxW'(cfg_i.rank), IdxW'(col_q)};
            mrg_own_d   = 1'b0;
            is_inc_d    = 1'b0;
          end else begin
            ram_raddr_o = {IdxW'(row_q), IdxW'(col_q)};
            mrg_row_d   = 1'b0;
            is_inc_d    = 1'b0;
          end
          addr_d   = ram_raddr_o;
          rd_vld_d = vld_q[ram_raddr_o];
          state_d  = S_RMW;
        end else if (dump_q) begin
          dump_d  = 1'b0;
          dr_d    = '0;
          dc_d    = '0;
          state_d = S_DUMP_RD;
        end else begin
          state_d = S_IDLE;
        end
      end

      // Read data is here: write back the updated counter.
      S_RMW: begin
        ram_we_o      = 1'b1;
        vld_d[addr_q] = 1'b1;
        state_d       = S_NEXT;
      end

      S_DUMP_RD: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = {dr_q, dc_q};
        rd_vld_d    = vld_q[ram_raddr_o];
        state_d     = S_DUMP_LD;
      end

      // Hold the beat until the output stage takes it.
      S_DUMP_LD: begin
        if (beat_ready_i) begin
          if (dump_end) begin
            state_d = S_IDLE;
          end else begin
            if ({1'b0, dc_q} == cnt_m1) begin
              dc_d = '0;
              dr_d = dr_q + IdxW'(1);
            end else begin
              dc_d = dc_q + IdxW'(1);
            end
            state_d = S_DUMP_RD;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // State and working registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      src_q     <= '0;
      inc_q     <= 1'b0;
      mrg_own_q <= 1'b0;
      mrg_row_q <= 1'b0;
      dump_q    <= 1'b0;
      is_inc_q  <= 1'b0;
      reason_q  <= RsnInternal;
      to_q      <= '0;
      dr_q      <= '0;
      dc_q      <= '0;
    end else begin
      state_q   <= state_d;
      vld_q     <= vld_d;
      rd_vld_q  <= rd_vld_d;
      src_q     <= src_d;
      inc_q     <= inc_d;
      mrg_own_q <= mrg_own_d;
      mrg_row_q <= mrg_row_d;
      dump_q    <= dump_d;
      is_inc_q  <= is_inc_d;
      reason_q  <= reason_d;
      to_q      <= to_d;
      dr_q      <= dr_d;
      dc_q      <= dc_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    row_q  <= row_d;
    col_q  <= col_d;
    val_q  <= val_d;
  end

  // The single memory never reads and writes in the same cycle.
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we_o && ram_re_o))
    else $error("memory read and write in the same cycle");

  // A write-back always follows a read of the same entry.
  a_rmw_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> $past(ram_re_o) && ($past(ram_raddr_o) == ram_waddr_o))
    else $error("write-back without a matching read");

  // A written entry is marked valid.
  a_valid_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |=> vld_q[$past(ram_waddr_o)])
    else $error("written entry not marked valid");

  // The final dump beat returns the sequencer to idle.
  a_idle_after_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_valid_o && beat_ready_i && beat_o.last |=> state_q == S_IDLE)
    else $error("sequencer not idle after the final dump beat");

endmodule

`default_nettype wire

// ===== rtl/matrix_clock_event_update_unit.sv =====
// ============================================================================
// Matrix clock event update unit
// Keeps one process's matrix clock in a counter memory, applies local and
// received events, and streams out the matrix after each completed event.
// ============================================================================
// Items are taken one at a time; every counter update is a read-modify-write
// on the counter memory, a read and then a write-back of the same entry. An
// internal, send or receive-start beat steps the own diagonal entry (unless
// the own rank is not below the process count); a received element merges
// into up to two entries. A dump then reads the matrix entry by entry,
// count*count entries, and the input stays stalled until its last beat
// enters the output register. After reset the matrix reads as all zeros at
// once through per-entry valid bits; there is no clearing pass.
`default_nettype none

module matrix_clock_event_update_unit
  import mceu_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Configuration writes.
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  // Event stream.
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // peer[2:0], elem_row[5:3], elem_col[8:6], elem_value[40:9], zeros above
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  // opcode[1:0]
  input  wire logic [1:0]          s_axis_tuser_i,
  // elem_last
  input  wire logic                s_axis_tlast_i,
  // Dump stream.
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // send_to[2:0], dump_row[5:3], dump_col[8:6], dump_value[40:9], zeros above
  output logic [OutDataW-1:0]      m_axis_tdata_o,
  // dump_reason[1:0]
  output logic [1:0]               m_axis_tuser_o,
  // dump_last
  output logic                     m_axis_tlast_o
);

  logic [RankW-1:0]      rank_q;
  logic [ProcCountW-1:0] pcount_q;
  cfg_t                  cfg;
  item_t                 item;
  beat_t                 beat;
  logic                  beat_valid;
  logic                  beat_ready;
  logic                  out_valid_q;
  beat_t                 out_q;

  logic                  ram_we;
  logic [AddrW-1:0]      ram_waddr;
  logic [CounterW-1:0]   ram_wdata;
  logic                  ram_re;
  logic [AddrW-1:0]      ram_raddr;
  logic [CounterW-1:0]   ram_rdata;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q   <= '0;
      pcount_q <= ProcCountW'(MaxProcs);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgOwnRank:   rank_q   <= cfg_data_i[RankW-1:0];
        CfgProcCount: pcount_q <= cfg_data_i[ProcCountW-1:0];
        default:      ;
      endcase
    end
  end

  // Process count limited to one through the group size.
  always_comb begin
    cfg.rank = rank_q;
    if (pcount_q == '0) begin
      cfg.count = CountW'(1);
    end else if (pcount_q > ProcCountW'(MaxProcs)) begin
      cfg.count = CountW'(MaxProcs);
    end else begin
      cfg.count = CountW'(pcount_q);
    end
  end

  // Unpack the input beat.
  always_comb begin
    item.op    = op_e'(s_axis_tuser_i);
    item.peer  = s_axis_tdata_i[2:0];
    item.row   = s_axis_tdata_i[5:3];
    item.col   = s_axis_tdata_i[8:6];
    item.value = s_axis_tdata_i[40:9];
    item.last  = s_axis_tlast_i;
  end

  mceu_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (s_axis_tvalid_i),
    .item_ready_o (s_axis_tready_o),
    .item_i       (item),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .beat_valid_o (beat_valid),
    .beat_ready_i (beat_ready),
    .beat_o       (beat)
  );

  mceu_ram #(
    .Width (CounterW),
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Output register between the sequencer and the dump stream.
  assign beat_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (beat_ready) begin
      out_valid_q <= beat_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat_ready && beat_valid) begin
      out_q <= beat;
    end
  end

  // Pack the output beat.
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.reason;
  assign m_axis_tlast_o  = out_q.last;
  assign m_axis_tdata_o  = {(OutDataW - 41)'(0), out_q.value, out_q.col, out_q.row,
                            out_q.send_to};

endmodule

`default_nettype wire

// ===== bench/mceu_dump_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Matrix clock dump checker
// Watches the configuration port and both streams of the matrix clock event
// update unit. It keeps its own copy of the counter table, works out the dump
// beats that each accepted event beat causes, and compares every accepted
// dump beat with the oldest one still due.
// ============================================================================

module mceu_dump_checker
  import mceu_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                s_axis_tvalid_i,
  input  wire logic                s_axis_tready_i,
  // peer[2:0], elem_row[5:3], elem_col[8:6], elem_value[40:9], zeros above
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  // opcode[1:0]
  input  wire logic [1:0]          s_axis_tuser_i,
  input  wire logic                s_axis_tlast_i,
  input  wire logic                m_axis_tvalid_i,
  input  wire logic                m_axis_tready_i,
  // send_to[2:0], dump_row[5:3], dump_col[8:6], dump_value[40:9], zeros above
  input  wire logic [OutDataW-1:0] m_axis_tdata_i,
  // dump_reason[1:0]
  input  wire logic [1:0]          m_axis_tuser_i,
  input  wire logic                m_axis_tlast_i,
  output int                       mismatch_count_o,
  output int                       beats_due_o
);

  // Predicted state of the unit.
  logic [ValueW-1:0]     clock_tbl [Depth];
  logic [RankW-1:0]      src_rank;
  logic [RankW-1:0]      own_rank;
  logic [ProcCountW-1:0] proc_count;

  // Dump beats that are due but not yet seen on the output.
  beat_t dump_q[$];
  int    mismatches;
  int    beats_due;

  assign mismatch_count_o = mismatches;
  assign beats_due_o      = beats_due;

  // The process count is clamped to the range 1 to MaxProcs.
  function automatic int unsigned active_procs();
    if (proc_count == 0) return 1;
    if (proc_count > MaxProcs) return MaxProcs;
    return proc_count;
  endfunction

  // Queues one full dump, row by row over the active part of the table.
  task automatic push_dump(reason_e why, logic [RankW-1:0] to);
    int unsigned n;
    beat_t       b;
    n = active_procs();
    for (int unsigned r = 0; r < n; r++) begin
      for (int unsigned c = 0; c < n; c++) begin
        b.reason  = why;
        b.send_to = to;
        b.row     = r[RankW-1:0];
        b.col     = c[RankW-1:0];
        b.value   = clock_tbl[r * MaxProcs + c];
        b.last    = (r == n - 1) && (c == n - 1);
        dump_q.push_back(b);
      end
    end
  endtask

  // Raises one counter to a received value if that value is larger.
  task automatic raise_entry(int unsigned r, int unsigned c, logic [ValueW-1:0] v);
    if (clock_tbl[r * MaxProcs + c] < v) clock_tbl[r * MaxProcs + c] = v;
  endtask

  // Applies one accepted event beat to the predicted table.
  task automatic apply_event(item_t it);
    int unsigned       n;
    int unsigned       rank;
    logic [ValueW-1:0] cur;
    n    = active_procs();
    rank = own_rank;
    if (it.op != OpRecvElem) begin
      // A local event steps the own diagonal entry, saturating at the top.
      if (rank < n) begin
        cur = clock_tbl[rank * MaxProcs + rank];
        if (~cur < rank + 1) clock_tbl[rank * MaxProcs + rank] = '1;
        else clock_tbl[rank * MaxProcs + rank] = cur + rank + 1;
      end
      case (it.op)
        OpInternal: push_dump(RsnInternal, '0);
        OpSend:     push_dump(RsnSend, it.peer);
        default:    src_rank = it.peer;
      endcase
    end else begin
      // Elements outside the active table change nothing.
      if (it.row < n && it.col < n) begin
        if (it.row == src_rank && it.col != rank && rank < n)
          raise_entry(rank, it.col, it.value);
        if (it.row != rank) raise_entry(it.row, it.col, it.value);
      end
      if (it.last) push_dump(RsnRecv, '0);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    item_t in_beat;
    beat_t got;
    beat_t want;
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) clock_tbl[i] = '0;
      src_rank   = '0;
      own_rank   = '0;
      proc_count = ProcCountW'(8);
      dump_q.delete();
      mismatches = 0;
      beats_due  = 0;
    end else begin
      // Compare an accepted dump beat with the oldest one due.
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.reason  = reason_e'(m_axis_tuser_i);
        got.send_to = m_axis_tdata_i[2:0];
        got.row     = m_axis_tdata_i[5:3];
        got.col     = m_axis_tdata_i[8:6];
        got.value   = m_axis_tdata_i[40:9];
        got.last    = m_axis_tlast_i;
        if (dump_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected dump beat", $realtime);
            $display("  actual   reason %0d to %0d row %0d col %0d value %h last %b",
                     got.reason, got.send_to, got.row, got.col, got.value, got.last);
          end
        end else begin
          want = dump_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: dump beat mismatch", $realtime);
              $display("  expected reason %0d to %0d row %0d col %0d value %h last %b",
                       want.reason, want.send_to, want.row, want.col, want.value,
                       want.last);
              $display("  actual   reason %0d to %0d row %0d col %0d value %h last %b",
                       got.reason, got.send_to, got.row, got.col, got.value, got.last);
            end
          end
        end
      end

      // Register writes.
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgOwnRank) own_rank = cfg_data_i[RankW-1:0];
        else if (cfg_idx_i == CfgProcCount) proc_count = cfg_data_i[ProcCountW-1:0];
      end

      // Predict from an accepted event beat.
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        in_beat.op    = op_e'(s_axis_tuser_i);
        in_beat.peer  = s_axis_tdata_i[2:0];
        in_beat.row   = s_axis_tdata_i[5:3];
        in_beat.col   = s_axis_tdata_i[8:6];
        in_beat.value = s_axis_tdata_i[40:9];
        in_beat.last  = s_axis_tlast_i;
        apply_event(in_beat);
      end
      beats_due = dump_q.size();
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Matrix clock event update unit testbench
// Drives local events and received matrices into the unit, with random gaps
// on the event stream and random stalls on the dump stream, across several
// rank and process count settings. A checker beside the unit predicts and
// compares every dump beat; this module makes the stimulus and the verdict.
// ============================================================================

module tb_top;
  import mceu_pkg::*;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  cfg_idx_e            cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [1:0]          s_axis_tuser;
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [1:0]          m_axis_tuser;
  logic                m_axis_tlast;
  int                  mismatches;
  int                  beats_due;

  // Stimulus bookkeeping.
  int          items_sent;
  bit          idle_en;
  bit          hold_req;
  int          hold_left;
  int unsigned cur_n;

  matrix_clock_event_update_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  mceu_dump_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .s_axis_tvalid_i  (s_axis_tvalid),
    .s_axis_tready_i  (s_axis_tready),
    .s_axis_tdata_i   (s_axis_tdata),
    .s_axis_tuser_i   (s_axis_tuser),
    .s_axis_tlast_i   (s_axis_tlast),
    .m_axis_tvalid_i  (m_axis_tvalid),
    .m_axis_tready_i  (m_axis_tready),
    .m_axis_tdata_i   (m_axis_tdata),
    .m_axis_tuser_i   (m_axis_tuser),
    .m_axis_tlast_i   (m_axis_tlast),
    .mismatch_count_o (mismatches),
    .beats_due_o      (beats_due)
  );

  // 10 ns clock.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Dump receiver: random stalls, plus one long hold-off when asked.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready = 1'b0;
      hold_left--;
    end else if (hold_req) begin
      hold_req      = 1'b0;
      hold_left     = 400;
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = !(idle_en && $urandom_range(0, 99) < 20);
    end
  end

  // Mostly small values so that merges compete, with the extremes mixed in.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 20);
      1:       return $urandom_range(0, 5000);
      2:       return $urandom;
      default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
    endcase
  endfunction

  // Offers one event beat, with a random gap first, and waits for acceptance.
  task automatic send_item(op_e op, logic [2:0] peer, logic [2:0] row, logic [2:0] col,
                           logic [31:0] val, logic last);
    @(negedge clk_i);
    while (idle_en && $urandom_range(0, 99) < 20) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {7'b0, val, col, row, peer};
    s_axis_tlast  = last;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // Local event; the element fields carry noise that the unit must ignore.
  task automatic send_event(op_e op, logic [2:0] peer);
    send_item(op, peer, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), $urandom,
              1'($urandom_range(0, 1)));
  endtask

  task automatic send_elem(logic [2:0] row, logic [2:0] col, logic [31:0] val, logic last);
    send_item(OpRecvElem, 3'($urandom_range(0, 7)), row, col, val, last);
  endtask

  // Waits until every dump beat has arrived and the unit has gone quiet.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (beats_due != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(negedge clk_i);
    cfg_we   = 1'b0;
  endtask

  task automatic set_config(logic [2:0] rank, logic [3:0] count);
    settle();
    write_reg(CfgOwnRank, {1'b0, rank});
    write_reg(CfgProcCount, count);
    cur_n = (count == 0) ? 1 : (count > 8) ? 8 : count;
  endtask

  // A received matrix in row order; now and then an element falls outside
  // the active table, and now and then the matrix is cut short.
  task automatic recv_sequence();
    int          total;
    int          cut;
    int unsigned r;
    int unsigned c;
    total = cur_n * cur_n;
    cut   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, total) : total + 1;
    send_event(OpRecvStart, 3'($urandom_range(0, 7)));
    for (int k = 0; k < total && k < cut; k++) begin
      r = k / cur_n;
      c = k % cur_n;
      if (cur_n < 8 && $urandom_range(0, 11) == 0) begin
        if ($urandom_range(0, 1)) r = $urandom_range(cur_n, 7);
        else c = $urandom_range(cur_n, 7);
      end
      send_elem(r[2:0], c[2:0], pick_value(), k == total - 1);
    end
  endtask

  // Run limit.
  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int          directed_end;
    int          phase_start;
    bit          pressure_done;
    int unsigned k;
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CfgOwnRank;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OpInternal;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    items_sent    = 0;
    idle_en       = 1'b1;
    hold_req      = 1'b0;
    hold_left     = 0;
    cur_n         = 8;
    pressure_done = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: rank 0 over the full table.
    send_event(OpInternal, 3'd0);
    send_event(OpSend, 3'd7);
    send_event(OpRecvStart, 3'd5);
    send_elem(3'd5, 3'd3, 32'hFFFF_FFFF, 1'b0);
    send_elem(3'd0, 3'd1, 32'h0, 1'b0);
    send_elem(3'd0, 3'd0, 32'hAAAA_AAAA, 1'b0);
    send_elem(3'd7, 3'd7, 32'h5555_5555, 1'b1);
    // Elements with no receive start merge against the old source.
    send_elem(3'd5, 3'd4, 32'h0000_0123, 1'b1);

    // Own rank above the process count: no diagonal step, and an element
    // outside the table still ends the receive.
    set_config(3'd7, 4'd2);
    send_event(OpInternal, 3'd0);
    send_event(OpSend, 3'd0);
    send_event(OpRecvStart, 3'd1);
    send_elem(3'd1, 3'd0, 32'h0000_0040, 1'b0);
    send_elem(3'd5, 3'd1, 32'h7777_7777, 1'b1);

    // A process count of zero acts as one.
    set_config(3'd3, 4'd0);
    send_event(OpInternal, 3'd2);
    send_elem(3'd0, 3'd0, 32'h0000_0009, 1'b1);

    // A count above the maximum acts as the maximum; push a foreign diagonal
    // to the top so that it saturates once it becomes the own entry.
    set_config(3'd0, 4'd15);
    send_event(OpRecvStart, 3'd0);
    send_elem(3'd1, 3'd1, 32'hFFFF_FFFF, 1'b1);
    set_config(3'd1, 4'd8);
    send_event(OpInternal, 3'd0);
    send_event(OpInternal, 3'd0);
    send_event(OpSend, 3'd3);

    // Random part.
    directed_end = items_sent;
    phase_start  = items_sent - 30;
    while (items_sent < directed_end + 85) begin
      // One long receiver hold-off while local events pile up.
      if (!pressure_done && items_sent - directed_end >= 35) begin
        pressure_done = 1'b1;
        hold_req      = 1'b1;
        repeat (3) send_event(OpInternal, 3'd0);
      end
      idle_en = !(items_sent - directed_end >= 50 && items_sent - directed_end < 75);
      if (items_sent - phase_start >= 30) begin
        set_config(3'($urandom_range(0, 7)),
                   4'(($urandom_range(0, 4) != 0) ? $urandom_range(2, 4)
                                                  : $urandom_range(0, 15)));
        phase_start = items_sent;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: recv_sequence();
        5: send_event(OpInternal, 3'($urandom_range(0, 7)));
        6: send_event(OpSend, 3'($urandom_range(0, 7)));
        7: send_elem(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), pick_value(),
                     $urandom_range(0, 3) == 0);
        8: send_event(OpRecvStart, 3'($urandom_range(0, 7)));
        default: begin
          // A few elements with no receive start ahead of them.
          k = $urandom_range(1, 4);
          for (int unsigned i = 0; i < k; i++)
            send_elem(3'($urandom_range(0, cur_n - 1)), 3'($urandom_range(0, cur_n - 1)),
                      pick_value(), (i == k - 1) && $urandom_range(0, 1));
        end
      endcase
    end
    idle_en = 1'b1;

    settle();
    if (mismatches == 0 && beats_due == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
